>>> rtl/core/svt_pkg.sv
package svt_pkg;

    // Coordinate format: signed, 8 fraction bits
    localparam int COORD_W       = 20;
    localparam int BOUND_W       = 2 * COORD_W;
    localparam int STORED_W      = 7;
    localparam int MAX_BOXES_DEF = 64;

    // Corner and segment counts of one rectangle
    localparam int CORNERS = 4;
    localparam int SEGS    = 6;

    // Stages of the test unit: three side stages and one combine stage
    localparam int TEST_LAT = 4;
    // Memory read stage plus test unit
    localparam int PIPE_D   = TEST_LAT + 1;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [1:0] kind_t;
    typedef logic [1:0] corner_idx_t;

    localparam kind_t KIND_CLEAR = 2'd0;
    localparam kind_t KIND_ADD   = 2'd1;
    localparam kind_t KIND_QUERY = 2'd2;

    localparam corner_idx_t C_LD = 2'd0;
    localparam corner_idx_t C_LU = 2'd1;
    localparam corner_idx_t C_RD = 2'd2;
    localparam corner_idx_t C_RU = 2'd3;

    // Four sides, then the two diagonals
    localparam corner_idx_t SEG_A [SEGS] = '{C_LD, C_RD, C_RU, C_LU, C_LD, C_RD};
    localparam corner_idx_t SEG_B [SEGS] = '{C_RD, C_RU, C_LU, C_LD, C_RU, C_LU};

    typedef struct packed {
        kind_t  kind;
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_max_x;
        coord_t box_max_y;
        coord_t from_x;
        coord_t from_y;
        coord_t to_x;
        coord_t to_y;
    } in_item_t;

    typedef struct packed {
        logic                visible;
        logic [STORED_W-1:0] stored_boxes;
    } out_item_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } pt_t;

    typedef struct packed {
        pt_t head;
        pt_t tail;
    } seg_t;

    typedef struct packed {
        logic pos;
        logic neg;
    } sign_t;

    // Product of two signs is strictly positive
    function automatic logic same_side(sign_t s1, sign_t s2);
        return (s1.pos & s2.pos) | (s1.neg & s2.neg);
    endfunction

endpackage

>>> rtl/core/svt_ram.sv
module svt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/svt_side.sv
module svt_side import svt_pkg::*; (
    input  logic  clk,
    input  pt_t   a,
    input  pt_t   b,
    input  pt_t   t,
    output sign_t side
);

    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int CROSS_W = PROD_W + 1;

    logic signed [DIFF_W-1:0]  dbx_reg, dby_reg, dtx_reg, dty_reg;
    logic signed [DIFF_W-1:0]  dbx_next, dby_next, dtx_next, dty_next;
    logic signed [PROD_W-1:0]  pa_reg, pb_reg;
    logic signed [PROD_W-1:0]  pa_next, pb_next;
    logic signed [CROSS_W-1:0] cross_val;
    sign_t                     side_reg, side_next;

    // Form the edge and target vectors from the base point
    always_comb
    begin
        dbx_next = $signed({b.x[COORD_W-1], b.x}) - $signed({a.x[COORD_W-1], a.x});
        dby_next = $signed({b.y[COORD_W-1], b.y}) - $signed({a.y[COORD_W-1], a.y});
        dtx_next = $signed({t.x[COORD_W-1], t.x}) - $signed({a.x[COORD_W-1], a.x});
        dty_next = $signed({t.y[COORD_W-1], t.y}) - $signed({a.y[COORD_W-1], a.y});
    end

    // Multiply the cross terms
    always_comb
    begin
        pa_next = dby_reg * dtx_reg;
        pb_next = dty_reg * dbx_reg;
    end

    // Subtract and keep the sign only
    always_comb
    begin
        cross_val      = $signed({pa_reg[PROD_W-1], pa_reg})
                       - $signed({pb_reg[PROD_W-1], pb_reg});
        side_next.neg  = cross_val[CROSS_W-1];
        side_next.pos  = !cross_val[CROSS_W-1] && (cross_val != '0);
    end

    always_ff @(posedge clk)
    begin
        dbx_reg  <= dbx_next;
        dby_reg  <= dby_next;
        dtx_reg  <= dtx_next;
        dty_reg  <= dty_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        side_reg <= side_next;
    end

    assign side = side_reg;

endmodule

>>> rtl/core/svt_test.sv
module svt_test import svt_pkg::*; (
    input  logic               clk,
    input  logic [BOUND_W-1:0] x_bounds,
    input  logic [BOUND_W-1:0] y_bounds,
    input  seg_t               seg,
    output logic               blocked
);

    pt_t          corner [CORNERS];
    sign_t        ef     [SEGS];
    sign_t        et     [SEGS];
    sign_t        cs     [CORNERS];
    logic [SEGS-1:0] hit;
    logic         blocked_reg, blocked_next;

    // Build the corners from the stored bounds
    always_comb
    begin
        corner[C_LD] = '{x: x_bounds[COORD_W-1:0],       y: y_bounds[COORD_W-1:0]};
        corner[C_LU] = '{x: x_bounds[COORD_W-1:0],       y: y_bounds[BOUND_W-1:COORD_W]};
        corner[C_RD] = '{x: x_bounds[BOUND_W-1:COORD_W], y: y_bounds[COORD_W-1:0]};
        corner[C_RU] = '{x: x_bounds[BOUND_W-1:COORD_W], y: y_bounds[BOUND_W-1:COORD_W]};
    end

    // Side of each segment endpoint against every box edge and diagonal
    for (genvar k = 0; k < SEGS; k++)
    begin : g_edge
        svt_side u_side_head (
            .clk  (clk),
            .a    (corner[SEG_A[k]]),
            .b    (corner[SEG_B[k]]),
            .t    (seg.head),
            .side (ef[k])
        );
        svt_side u_side_tail (
            .clk  (clk),
            .a    (corner[SEG_A[k]]),
            .b    (corner[SEG_B[k]]),
            .t    (seg.tail),
            .side (et[k])
        );
    end

    // Side of each corner against the query segment
    for (genvar c = 0; c < CORNERS; c++)
    begin : g_corner
        svt_side u_side (
            .clk  (clk),
            .a    (seg.head),
            .b    (seg.tail),
            .t    (corner[c]),
            .side (cs[c])
        );
    end

    // Combine: a segment pair is apart only if one straddle test fails
    always_comb
    begin
        for (int k = 0; k < SEGS; k++)
        begin
            hit[k] = !same_side(ef[k], et[k]) && !same_side(cs[SEG_A[k]], cs[SEG_B[k]]);
        end
        blocked_next = |hit;
    end

    always_ff @(posedge clk)
    begin
        blocked_reg <= blocked_next;
    end

    assign blocked = blocked_reg;

endmodule

>>> rtl/core/svt_ctrl.sv
module svt_ctrl import svt_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF,
    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1,
    localparam int CNT_W  = $clog2(MAX_BOXES + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  in_item_t           item,
    output logic               result_valid,
    input  logic               result_stall,
    output out_item_t          result,
    output logic               wr_en,
    output logic [ADDR_W-1:0]  wr_addr,
    output logic [BOUND_W-1:0] x_wr_data,
    output logic [BOUND_W-1:0] y_wr_data,
    output logic               rd_en,
    output logic [ADDR_W-1:0]  rd_addr,
    output seg_t               seg,
    input  logic               blocked
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DRAIN, S_DONE} state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [PIPE_D-1:0] vld_reg, vld_next;
    logic              acc_reg, acc_next;
    logic              res_valid_reg, res_valid_next;
    seg_t              seg_reg, seg_next;
    out_item_t         res_reg, res_next;
    logic              load;

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign seg          = seg_reg;
    assign wr_addr      = count_reg[ADDR_W-1:0];
    assign rd_addr      = idx_reg[ADDR_W-1:0];
    assign x_wr_data    = {item.box_max_x, item.box_min_x};
    assign y_wr_data    = {item.box_max_y, item.box_min_y};

    // Sequence: store updates complete in idle, queries scan unless the store is empty
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        seg_next   = seg_reg;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        load       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    unique case (item.kind)
                        KIND_CLEAR:
                        begin
                            count_next = '0;
                        end
                        KIND_ADD:
                        begin
                            // Drop the add when the store is full
                            if (count_reg < CNT_W'(MAX_BOXES))
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_QUERY:
                        begin
                            seg_next = '{head: '{x: item.from_x, y: item.from_y},
                                         tail: '{x: item.to_x,   y: item.to_y}};
                            acc_next = 1'b0;
                            idx_next = '0;
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                rd_en    = 1'b1;
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg + CNT_W'(1) == count_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (vld_reg == '0)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        // Track reads through the memory and the test unit
        vld_next = {vld_reg[PIPE_D-2:0], rd_en};

        // Accumulate blocked boxes
        if (vld_reg[PIPE_D-1] && blocked)
        begin
            acc_next = 1'b1;
        end

        // Hold the result until taken
        res_next = res_reg;
        if (load)
        begin
            res_valid_next        = 1'b1;
            res_next.visible      = !acc_reg;
            res_next.stored_boxes = STORED_W'(count_reg);
        end
        else if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            vld_reg       <= '0;
            acc_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            vld_reg       <= vld_next;
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
        res_reg <= res_next;
    end

endmodule

>>> rtl/core/segment_box_visibility_test_top.sv
// Segment versus box visibility tester.
// Input channel item/item_valid/item_stall carries one transaction per item:
// a clear empties the rectangle store, an add appends one rectangle (dropped
// when MAX_BOXES are held), a query tests a segment against every stored
// rectangle's four sides and two diagonals. Kind 3 is ignored.
// Output channel result/result_valid/result_stall carries one transaction
// per query: the visible flag and the number of rectangles held.
// Clears and adds complete in the idle state. A query with N stored
// rectangles scans them in order: the scan reads one rectangle a cycle
// from the bound memories and feeds it to sixteen side-test lanes, then
// waits for the memory read and the four-stage test pipeline to drain,
// and then loads the output register. An empty store skips the scan.
// The input stalls for the whole query, so the next item is taken only
// once the query has loaded its result.
// The output register parts the channels: the next item is accepted while a
// result still waits. A stalled result holds; a finished query then waits
// until the output register is free.
// Reset clears the rectangle count and the control state; the bound
// memories are not cleared and need no clearing pass.
module segment_box_visibility_test_top import svt_pkg::*; #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [BOUND_W-1:0] x_wr_data, y_wr_data;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [BOUND_W-1:0] x_bounds, y_bounds;
    seg_t               seg;
    logic               blocked;

    svt_ctrl #(
        .MAX_BOXES (MAX_BOXES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .x_wr_data    (x_wr_data),
        .y_wr_data    (y_wr_data),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .seg          (seg),
        .blocked      (blocked)
    );

    // X bounds: min low, max high
    svt_ram #(
        .WIDTH (BOUND_W),
        .DEPTH (MAX_BOXES)
    ) u_x_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (x_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (x_bounds)
    );

    // Y bounds: min low, max high
    svt_ram #(
        .WIDTH (BOUND_W),
        .DEPTH (MAX_BOXES)
    ) u_y_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (y_wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (y_bounds)
    );

    svt_test u_test (
        .clk      (clk),
        .x_bounds (x_bounds),
        .y_bounds (y_bounds),
        .seg      (seg),
        .blocked  (blocked)
    );

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import svt_pkg::*;

    localparam kind_t KIND_UNUSED  = 2'd3;
    localparam int    ITEM_TARGET  = 1420;
    localparam int    HOLD_CYCLES  = 400;
    localparam int    DRAIN_CYCLES = 100;
    localparam int    LIMIT_CYCLES = 1000000;
    localparam int    PLAN_N       = 25;

    // One directed stimulus row; chk marks a result typed in by hand
    typedef struct packed {
        kind_t      kind;
        coord_t     nx;
        coord_t     ny;
        coord_t     xx;
        coord_t     xy;
        coord_t     fx;
        coord_t     fy;
        coord_t     tx;
        coord_t     ty;
        logic [7:0] reps;
        logic       chk;
        logic       vis;
        logic [6:0] cnt;
    } step_row_t;

    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
    } corner_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    // Obstacle store as the checker sees it
    coord_t    held_nx [MAX_BOXES_DEF];
    coord_t    held_ny [MAX_BOXES_DEF];
    coord_t    held_xx [MAX_BOXES_DEF];
    coord_t    held_xy [MAX_BOXES_DEF];
    int        held_count;

    out_item_t pending_answers [$];
    step_row_t plan_rows [PLAN_N];

    logic      row_chk;
    out_item_t row_want;
    logic      snd_idle_on;
    logic      rcv_idle_on;
    logic      pressure_arm;
    logic      pressure_done;

    int        errors;
    int        cycles;
    int        n_sent;
    int        n_accepted;
    int        n_checked;
    int        n_blocked;
    int        adds_dropped;

    logic      got_answer;
    out_item_t answer;
    out_item_t want;

    segment_box_visibility_test_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Sign of the cross product of (t - a) and (b - a)
    function automatic int side_sign(corner_t a, corner_t b, corner_t t);
        logic signed [63:0] v;
        v = (b.y - a.y) * (t.x - a.x) - (t.y - a.y) * (b.x - a.x);
        if (v > 0)
            return 1;
        if (v < 0)
            return -1;
        return 0;
    endfunction

    // Apart only when both ends of one lie strictly on one side of the other
    function automatic bit segments_meet(corner_t p1, corner_t p2, corner_t q1, corner_t q2);
        if (side_sign(p1, p2, q1) * side_sign(p1, p2, q2) > 0)
            return 1'b0;
        if (side_sign(q1, q2, p1) * side_sign(q1, q2, p2) > 0)
            return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit rect_blocks(int i, corner_t f, corner_t t);
        corner_t ld;
        corner_t lu;
        corner_t rd;
        corner_t ru;
        ld.x = held_nx[i];
        ld.y = held_ny[i];
        lu.x = held_nx[i];
        lu.y = held_xy[i];
        rd.x = held_xx[i];
        rd.y = held_ny[i];
        ru.x = held_xx[i];
        ru.y = held_xy[i];
        return segments_meet(ld, rd, f, t) || segments_meet(rd, ru, f, t) ||
               segments_meet(ru, lu, f, t) || segments_meet(lu, ld, f, t) ||
               segments_meet(ld, ru, f, t) || segments_meet(rd, lu, f, t);
    endfunction

    // Advance the store by one transaction and work out its answer, if any
    task automatic apply_to_store(input in_item_t it, output logic has_res,
                                  output out_item_t res);
        corner_t f;
        corner_t t;
        logic    vis;
        int      i;
        has_res = 1'b0;
        res     = '0;
        case (it.kind)
            KIND_CLEAR:
                held_count = 0;
            KIND_ADD:
            begin
                if (held_count < MAX_BOXES_DEF)
                begin
                    held_nx[held_count] = it.box_min_x;
                    held_ny[held_count] = it.box_min_y;
                    held_xx[held_count] = it.box_max_x;
                    held_xy[held_count] = it.box_max_y;
                    held_count++;
                end
                else
                begin
                    adds_dropped++;
                end
            end
            KIND_QUERY:
            begin
                f.x = it.from_x;
                f.y = it.from_y;
                t.x = it.to_x;
                t.y = it.to_y;
                vis = 1'b1;
                for (i = 0; i < held_count; i++)
                begin
                    if (rect_blocks(i, f, t))
                    begin
                        vis = 1'b0;
                        break;
                    end
                end
                res.visible      = vis;
                res.stored_boxes = held_count[STORED_W-1:0];
                has_res          = 1'b1;
            end
            default:
                ;
        endcase
    endtask

    // Check answers first, then predict for the transaction taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_answers.size() == 0)
                begin
                    $display("%0t: result with none pending: visible=%0b stored_boxes=%0d",
                             $time, result.visible, result.stored_boxes);
                    errors++;
                end
                else
                begin
                    want = pending_answers.pop_front();
                    if (result.visible !== want.visible)
                    begin
                        $display("%0t: visible mismatch: expected %0b, got %0b",
                                 $time, want.visible, result.visible);
                        errors++;
                    end
                    if (result.stored_boxes !== want.stored_boxes)
                    begin
                        $display("%0t: stored_boxes mismatch: expected %0d, got %0d",
                                 $time, want.stored_boxes, result.stored_boxes);
                        errors++;
                    end
                    n_checked++;
                    if (result.visible === 1'b0)
                        n_blocked++;
                end
            end
            if (item_valid && !item_stall)
            begin
                n_accepted++;
                apply_to_store(item, got_answer, answer);
                if (got_answer)
                    pending_answers = {pending_answers, (row_chk ? row_want : answer)};
            end
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("%0t: timeout with %0d answers pending", $time, pending_answers.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap(logic on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic coord_t clamp20(int v);
        if (v > 524287)
            return coord_t'(524287);
        if (v < -524288)
            return coord_t'(-524288);
        return coord_t'(v);
    endfunction

    // Mostly a local working area, with grid points, full range and extremes
    function automatic coord_t rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return coord_t'((int'($urandom_range(0, 16)) - 8) * 256);
            7:       return coord_t'($urandom());
            8:
            begin
                case ($urandom_range(0, 3))
                    0:       return coord_t'(-524288);
                    1:       return coord_t'(524287);
                    2:       return coord_t'(0);
                    default: return coord_t'(-1);
                endcase
            end
            9:       return coord_t'(int'($urandom_range(0, 600)) - 300);
            default: return coord_t'(int'($urandom_range(0, 16383)) - 8192);
        endcase
    endfunction

    // Offer one transaction and hold it until taken; entered and left at a falling edge
    task automatic send_txn(in_item_t it, logic chk, out_item_t typed);
        int gap;
        gap = pick_gap(snd_idle_on);
        if (gap > 0)
        begin
            item_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       = it;
        row_chk    = chk;
        row_want   = typed;
        item_valid = 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
    endtask

    task automatic send_random(kind_t k);
        in_item_t it;
        int       r;
        it           = '0;
        it.kind      = k;
        it.box_min_x = rand_coord();
        it.box_min_y = rand_coord();
        it.box_max_x = rand_coord();
        it.box_max_y = rand_coord();
        it.from_x    = rand_coord();
        it.from_y    = rand_coord();
        it.to_x      = rand_coord();
        it.to_y      = rand_coord();
        if (k == KIND_ADD)
        begin
            // Mostly well-ordered boxes, some with swapped bounds, rest as drawn
            r = $urandom_range(0, 19);
            if (r < 14)
            begin
                it.box_max_x = clamp20(int'(it.box_min_x) + int'($urandom_range(0, 4096)));
                it.box_max_y = clamp20(int'(it.box_min_y) + int'($urandom_range(0, 4096)));
            end
            else if (r < 17)
            begin
                it.box_max_x = clamp20(int'(it.box_min_x) - int'($urandom_range(0, 4096)));
                it.box_max_y = clamp20(int'(it.box_min_y) - int'($urandom_range(0, 4096)));
            end
        end
        if (k == KIND_QUERY && $urandom_range(0, 9) < 7)
        begin
            it.to_x = clamp20(int'(it.from_x) + int'($urandom_range(0, 8192)) - 4096);
            it.to_y = clamp20(int'(it.from_y) + int'($urandom_range(0, 8192)) - 4096);
        end
        send_txn(it, 1'b0, '0);
        n_sent++;
    endtask

    // Drop in an ignored kind now and then, with random content
    task automatic maybe_noise();
        in_item_t it;
        if ($urandom_range(0, 24) == 0)
        begin
            it      = in_item_t'({$urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom()});
            it.kind = KIND_UNUSED;
            send_txn(it, 1'b0, '0);
        end
    endtask

    // Result side: random stalls, one long hold-off to back the block up
    initial
    begin
        int run_left;
        int r;
        run_left      = 0;
        result_stall  = 1'b0;
        pressure_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_arm && !pressure_done)
            begin
                result_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                pressure_done = 1'b1;
                run_left      = 0;
            end
            if (run_left > 0)
            begin
                run_left--;
            end
            else if (!rcv_idle_on)
            begin
                result_stall = 1'b0;
                run_left     = $urandom_range(0, 20);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    result_stall = 1'b0;
                    run_left     = $urandom_range(0, 4);
                end
                else
                begin
                    result_stall = 1'b1;
                    run_left     = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 50);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int        r;
        int        nb;
        int        nq;
        step_row_t row;
        in_item_t  it;
        out_item_t typed;
        errors       = 0;
        cycles       = 0;
        n_sent       = 0;
        n_accepted   = 0;
        n_checked    = 0;
        n_blocked    = 0;
        adds_dropped = 0;
        held_count   = 0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        row_chk      = 1'b0;
        row_want     = '0;
        snd_idle_on  = 1'b1;
        rcv_idle_on  = 1'b1;
        pressure_arm = 1'b0;

        // kind, box min x/y, box max x/y, from x/y, to x/y, repeats, typed, visible, count
        plan_rows = '{
            // empty store answers visible
            '{KIND_QUERY, 0, 0, 0, 0, 0, 0, 524287, 524287, 1, 1, 1, 0},
            '{KIND_UNUSED, -1, -1, -1, -1, -1, -1, -1, -1, 1, 0, 0, 0},
            '{KIND_ADD, -256, -256, 256, 256, 0, 0, 0, 0, 1, 0, 0, 0},
            // straight through the box
            '{KIND_QUERY, 0, 0, 0, 0, -1024, 0, 1024, 0, 1, 1, 0, 1},
            '{KIND_QUERY, 0, 0, 0, 0, 1024, -2048, 2048, -1024, 1, 1, 1, 1},
            // end touching a corner
            '{KIND_QUERY, 0, 0, 0, 0, 256, 256, 1024, 2048, 1, 1, 0, 1},
            // collinear with the bottom edge but clear of it
            '{KIND_QUERY, 0, 0, 0, 0, 512, -256, 1024, -256, 1, 0, 0, 0},
            '{KIND_ADD, -524288, -524288, 524287, 524287, 0, 0, 0, 0, 1, 0, 0, 0},
            '{KIND_QUERY, 0, 0, 0, 0, -524288, -524288, 524287, 524287, 1, 1, 0, 2},
            // zero-length segment
            '{KIND_QUERY, 0, 0, 0, 0, 5000, 3000, 5000, 3000, 1, 0, 0, 0},
            // swapped bounds
            '{KIND_ADD, 2048, 2048, 1024, 1024, 0, 0, 0, 0, 1, 0, 0, 0},
            '{KIND_QUERY, 0, 0, 0, 0, 1536, 0, 1536, 4096, 1, 0, 0, 0},
            '{KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
            '{KIND_QUERY, 0, 0, 0, 0, -524288, 524287, 524287, -524288, 1, 1, 1, 0},
            // zero-size box
            '{KIND_ADD, 100, 100, 100, 100, 0, 0, 0, 0, 1, 0, 0, 0},
            '{KIND_QUERY, 0, 0, 0, 0, 0, 0, 200, 200, 1, 0, 0, 0},
            '{KIND_QUERY, 0, 0, 0, 0, 100, 100, 100, 100, 1, 0, 0, 0},
            '{KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
            // fill the store and overrun it by one
            '{KIND_ADD, 10000, 10000, 10256, 10256, 0, 0, 0, 0, 65, 0, 0, 0},
            '{KIND_QUERY, 0, 0, 0, 0, 0, 0, 256, 0, 1, 1, 1, 64},
            '{KIND_ADD, -100, -100, 100, 100, 0, 0, 0, 0, 1, 0, 0, 0},
            '{KIND_QUERY, 0, 0, 0, 0, -524288, 0, 524287, 0, 1, 0, 0, 0},
            '{KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
            '{KIND_QUERY, 0, 0, 0, 0, -1, -1, -1, -1, 1, 1, 1, 0},
            '{KIND_ADD, -1, -1, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0}
        };

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed rows
        for (r = 0; r < PLAN_N; r++)
        begin
            row                = plan_rows[r];
            it.kind            = row.kind;
            it.box_min_x       = row.nx;
            it.box_min_y       = row.ny;
            it.box_max_x       = row.xx;
            it.box_max_y       = row.xy;
            it.from_x          = row.fx;
            it.from_y          = row.fy;
            it.to_x            = row.tx;
            it.to_y            = row.ty;
            typed.visible      = row.vis;
            typed.stored_boxes = row.cnt;
            repeat (row.reps) send_txn(it, row.chk, typed);
        end

        // Hold the result side off while queries keep coming
        pressure_arm <= 1'b1;
        repeat (6) send_random(KIND_QUERY);

        // Random sequences: usually a clear, a batch of adds, then queries on that store
        while (n_sent < ITEM_TARGET)
        begin
            snd_idle_on = ($urandom_range(0, 3) != 0);
            rcv_idle_on <= ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 4) != 0)
            begin
                maybe_noise();
                send_random(KIND_CLEAR);
            end
            r = $urandom_range(0, 19);
            if (r < 12)
                nb = $urandom_range(0, 4);
            else if (r < 18)
                nb = $urandom_range(5, 16);
            else if (r < 19)
                nb = $urandom_range(30, 63);
            else
                nb = $urandom_range(64, 70);
            repeat (nb)
            begin
                maybe_noise();
                send_random(KIND_ADD);
            end
            nq = $urandom_range(1, 8);
            repeat (nq)
            begin
                maybe_noise();
                send_random(KIND_QUERY);
            end
        end
        item_valid = 1'b0;

        // Drain outstanding answers, then let the block settle
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d transactions in, %0d queries answered (%0d blocked),",
                 n_accepted, n_checked, n_blocked);
        $display("%0d adds dropped on a full store, %0d mismatches", adds_dropped, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/svt_pkg.sv
rtl/core/svt_ram.sv
rtl/core/svt_side.sv
rtl/core/svt_test.sv
rtl/core/svt_ctrl.sv
rtl/core/segment_box_visibility_test_top.sv
sim/tb_top.sv
